// File: hw/rtl/sexl_pkg.sv
`default_nettype none
package sexl_pkg;

  localparam int SEXL_QUEUE_DEPTH = 4;
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    K_OPEN   = 4'd0,
    K_CLOSE  = 4'd1,
    K_QUOTE  = 4'd2,
    K_DOT    = 4'd3,
    K_CONST  = 4'd4,
    K_SYMCH  = 4'd5,
    K_SYMEND = 4'd6,
    K_END    = 4'd7,
    K_ERR    = 4'd8
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] number;
    logic        [7:0]  sym_char;
    logic               last_of_input;
  } tok_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] number;
    logic        [7:0]  sym_char;
  } entry_t;

  typedef struct packed {
    logic [1:0]       count;
    entry_t [2:0]     e;
  } bundle_t;

  typedef struct packed {
    logic    en;
    bundle_t bundle;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/sexl_front.sv
`default_nettype none
module sexl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sexl_pkg::item_t   item,
  input  sexl_pkg::q_stat_t q_stat,
  output sexl_pkg::push_t   push
);
  import sexl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_SIGN = 3'd1,
    M_NUM  = 3'd2,
    M_SYM  = 3'd3,
    M_ERR  = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [30:0] accum, accum_next;
  logic        neg_flag, neg_flag_next;
  logic [7:0]  held_sign, held_sign_next;

  logic        accept;
  logic [7:0]  c;
  logic        is_dig, is_sep, is_brk, is_sign, allowed;
  logic [34:0] acc_x10;
  logic [30:0] dig_val;
  logic        do_flush, do_idle, emit_end, emit_err, emit_sym;
  logic [1:0]  n;
  entry_t [2:0] slot;
  logic signed [31:0] const_val;

  function automatic entry_t mk(kind_t k, logic signed [31:0] num, logic [7:0] s);
    entry_t r;
    r.kind     = k;
    r.number   = num;
    r.sym_char = s;
    return r;
  endfunction

  function automatic logic is_allowed(logic [7:0] b);
    logic r;
    r = 1'b0;
    if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
      r = 1'b1;
    end
    if (b == "+" || b == "-" || b == "." || b == 8'h27 || b == "(" || b == ")" ||
        b == "<" || b == "=" || b == ">" || b == "*" || b == "/" || b == "#" ||
        b == "!" || b == "?" || b == " " || b == 8'h0A) begin
      r = 1'b1;
    end
    return r;
  endfunction

  assign accept     = item_valid && !q_stat.full;
  assign item_stall = q_stat.full;

  assign c       = item.ch;
  assign is_dig  = (c >= "0") && (c <= "9");
  assign is_sep  = (c == " ") || (c == 8'h0A);
  assign is_brk  = (c == "(") || (c == ")");
  assign is_sign = (c == "+") || (c == "-");
  assign allowed = is_allowed(c);
  assign dig_val = {27'd0, c[3:0]};
  assign acc_x10 = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + {4'd0, dig_val};
  assign const_val = neg_flag ? -$signed({1'b0, accum}) : $signed({1'b0, accum});

  always_comb begin
    mode_next      = mode;
    accum_next     = accum;
    neg_flag_next  = neg_flag;
    held_sign_next = held_sign;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    emit_end = 1'b0;
    emit_err = 1'b0;
    emit_sym = 1'b0;
    n    = 2'd0;
    slot = '0;

    if (mode == M_ERR) begin
      emit_err = 1'b1;
    end else if (item.end_mark) begin
      do_flush = 1'b1;
      emit_end = 1'b1;
    end else if (!allowed) begin
      do_flush = (mode == M_SIGN);
      emit_err = 1'b1;
    end else begin
      case (mode)
        M_IDLE: begin
          do_idle = 1'b1;
        end
        M_SIGN: begin
          if (is_dig) begin
            mode_next     = M_NUM;
            neg_flag_next = (held_sign == "-");
            accum_next    = dig_val;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_NUM: begin
          if (is_dig) begin
            accum_next = (acc_x10 > {4'd0, MAG_MAX}) ? MAG_MAX : acc_x10[30:0];
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_SYM: begin
          if (is_sep || is_brk) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end else begin
            emit_sym = 1'b1;
          end
        end
        default: begin
          emit_err = 1'b1;
        end
      endcase
    end

    if (do_flush) begin
      case (mode)
        M_SIGN: begin
          slot[n] = mk(K_SYMCH, 32'sd0, held_sign);
          n = n + 2'd1;
          slot[n] = mk(K_SYMEND, 32'sd0, 8'd0);
          n = n + 2'd1;
        end
        M_NUM: begin
          slot[n] = mk(K_CONST, const_val, 8'd0);
          n = n + 2'd1;
        end
        M_SYM: begin
          slot[n] = mk(K_SYMEND, 32'sd0, 8'd0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
    end

    if (do_idle) begin
      mode_next = M_IDLE;
      if (is_sep) begin
        mode_next = M_IDLE;
      end else if (c == "(") begin
        slot[n] = mk(K_OPEN, 32'sd0, 8'd0);
        n = n + 2'd1;
      end else if (c == ")") begin
        slot[n] = mk(K_CLOSE, 32'sd0, 8'd0);
        n = n + 2'd1;
      end else if (c == 8'h27) begin
        slot[n] = mk(K_QUOTE, 32'sd0, 8'd0);
        n = n + 2'd1;
      end else if (c == ".") begin
        slot[n] = mk(K_DOT, 32'sd0, 8'd0);
        n = n + 2'd1;
      end else if (is_dig) begin
        mode_next     = M_NUM;
        accum_next    = dig_val;
        neg_flag_next = 1'b0;
      end else if (is_sign) begin
        mode_next      = M_SIGN;
        held_sign_next = c;
      end else begin
        slot[n] = mk(K_SYMCH, 32'sd0, c);
        n = n + 2'd1;
        mode_next = M_SYM;
      end
    end

    if (emit_end) begin
      slot[n] = mk(K_END, 32'sd0, 8'd0);
      n = n + 2'd1;
      mode_next = M_IDLE;
    end
    if (emit_err) begin
      slot[n] = mk(K_ERR, 32'sd0, 8'd0);
      n = n + 2'd1;
      mode_next = M_ERR;
    end
    if (emit_sym) begin
      slot[n] = mk(K_SYMCH, 32'sd0, c);
      n = n + 2'd1;
    end
  end

  always_comb begin
    push.en           = accept && (n != 2'd0);
    push.bundle.count = n;
    push.bundle.e     = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      accum     <= '0;
      neg_flag  <= 1'b0;
      held_sign <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      accum     <= accum_next;
      neg_flag  <= neg_flag_next;
      held_sign <= held_sign_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sexl_queue.sv
`default_nettype none
module sexl_queue #(
  parameter int DEPTH = sexl_pkg::SEXL_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  sexl_pkg::push_t   push,
  input  logic              pop,
  output sexl_pkg::bundle_t head,
  output sexl_pkg::q_stat_t q_stat
);
  import sexl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push.en && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sexl_back.sv
`default_nettype none
module sexl_back (
  input  logic              clk,
  input  logic              rst,
  input  sexl_pkg::bundle_t head,
  input  sexl_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              tok_valid,
  input  logic              tok_stall,
  output sexl_pkg::tok_t    tok
);
  import sexl_pkg::*;

  logic [1:0] idx;
  logic       last;
  entry_t     cur;

  assign cur       = head.e[idx];
  assign last      = (idx == head.count - 2'd1);
  assign tok_valid = !q_stat.empty;
  assign pop       = tok_valid && !tok_stall && last;

  always_comb begin
    tok.kind          = cur.kind;
    tok.number        = cur.number;
    tok.sym_char      = cur.sym_char;
    tok.last_of_input = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (tok_valid && !tok_stall) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sexpr_lexer_step_unit.sv
`default_nettype none
// S-expression tokenizer. One character (or end mark) is taken per item and
// turned into zero to three tokens, which leave one per cycle on tok while
// tok_stall is low. The front end classifies an item combinationally and files
// its tokens as one bundle in a queue of QUEUE_DEPTH bundles; the back end
// sends the tokens of the head bundle in order and marks the last of each item.
// Items that give at most one token flow at one per cycle while tok_stall is
// low; an item that gives more than one token holds the output until all have
// left, so the sustained rate is set by the token count per item. item_stall
// rises only when the queue is full. A syntax error is sticky until reset.
module sexpr_lexer_step_unit #(
  parameter int QUEUE_DEPTH = sexl_pkg::SEXL_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  sexl_pkg::item_t item,
  output logic            tok_valid,
  input  logic            tok_stall,
  output sexl_pkg::tok_t  tok
);
  import sexl_pkg::*;

  push_t   push;
  bundle_t head;
  q_stat_t q_stat;
  logic    pop;

  sexl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_stat     (q_stat),
    .push       (push)
  );

  sexl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  sexl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok)
  );

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> tok_valid && tok.last_of_input)
    else $error("bundle popped before its last token");

  a_end_err_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok.kind == K_END || tok.kind == K_ERR) |-> tok.last_of_input)
    else $error("end or error token not last of its item");

  a_full_has_out: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> tok_valid)
    else $error("queue full with no token offered");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !tok_valid)
    else $error("token offered right after reset");

endmodule
`default_nettype wire
